// File: rtl/spos_pkg.sv
`default_nettype none

package spos_pkg;

  // Field widths
  localparam int unsigned AXIS_W  = 8;
  localparam int unsigned SW_W    = 16;
  localparam int unsigned CW_W    = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned CNT_W   = 20;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 20;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_INIT_CW = 2'd1;

  // Configuration reset values
  localparam logic [CNT_W-1:0] TIMEOUT_RST = 20'd1000;
  localparam logic [CW_W-1:0]  INIT_CW_RST = 16'h0000;

  // Control word bits (CiA 402)
  localparam logic [CW_W-1:0] CW_SO = 16'h0001;
  localparam logic [CW_W-1:0] CW_EV = 16'h0002;
  localparam logic [CW_W-1:0] CW_QS = 16'h0004;
  localparam logic [CW_W-1:0] CW_EO = 16'h0008;

  // Status word bits (CiA 402)
  localparam logic [SW_W-1:0] SW_RTSO = 16'h0001;
  localparam logic [SW_W-1:0] SW_SO   = 16'h0002;
  localparam logic [SW_W-1:0] SW_OE   = 16'h0004;
  localparam logic [SW_W-1:0] SW_QS   = 16'h0020;

  // Saturation value of the shared timeout counter
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Axis state commands
  localparam logic [CMD_W-1:0] CMD_NONE       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERROR_STOP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STANDSTILL = 2'd2;

  // Error codes
  localparam logic ERR_CODE_NONE    = 1'b0;
  localparam logic ERR_CODE_TIMEOUT = 1'b1;

  // One input word
  typedef struct packed {
    logic                    enable;
    logic [AXIS_W-1:0]       axis_id;
    logic [SW_W-1:0]         status_word;
    logic                    axis_fault;
    logic                    axis_powered_off;
    logic                    axis_virtual;
    logic signed [POS_W-1:0] actual_position;
  } item_t;

  // One result word
  typedef struct packed {
    logic                    busy_res;
    logic                    done_res;
    logic                    error;
    logic                    error_code;
    logic                    control_write;
    logic [CW_W-1:0]         control_word;
    logic                    set_csp_mode;
    logic [CMD_W-1:0]        axis_state_command;
    logic                    target_write;
    logic signed [POS_W-1:0] target_position;
  } result_t;

  // Configuration seen by the sequencer core
  typedef struct packed {
    logic [CNT_W-1:0] timeout_ticks;
    logic [CW_W-1:0]  init_control_word;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/spos_cfg.sv
`default_nettype none

module spos_cfg
  import spos_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire logic [CIDX_W-1:0]  wr_index,
  input  wire logic [CDATA_W-1:0] wr_data,
  output cfg_t                    cfg
);

  logic [CNT_W-1:0] timeout_r, timeout_nxt;
  logic [CW_W-1:0]  init_cw_r, init_cw_nxt;

  // Register decode; writes to unknown indexes are dropped.
  always_comb begin
    timeout_nxt = timeout_r;
    init_cw_nxt = init_cw_r;
    if (wr_en) begin
      if (wr_index == CFG_TIMEOUT) begin
        timeout_nxt = wr_data[CNT_W-1:0];
      end else if (wr_index == CFG_INIT_CW) begin
        init_cw_nxt = wr_data[CW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      init_cw_r <= INIT_CW_RST;
    end else begin
      timeout_r <= timeout_nxt;
      init_cw_r <= init_cw_nxt;
    end
  end

  assign cfg.timeout_ticks     = timeout_r;
  assign cfg.init_control_word = init_cw_r;

endmodule

`default_nettype wire

// File: rtl/spos_core.sv
`default_nettype none

module spos_core
  import spos_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  advance,
  input  item_t      item,
  input  cfg_t       cfg,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_READY  = 3'd0,
    PH_START  = 3'd1,
    PH_W06    = 3'd2,
    PH_W07    = 3'd3,
    PH_W0F    = 3'd4,
    PH_FINISH = 3'd5,
    PH_ERROR  = 3'd6
  } phase_t;

  phase_t            phase_r, phase_nxt, cur_ph;
  logic              prev_en_r, prev_en_nxt;
  logic              edge_r, edge_nxt;
  logic [AXIS_W-1:0] prev_axis_r, prev_axis_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;

  logic              hs_active;
  logic              hs_last;
  logic [CW_W-1:0]   hs_cw;
  logic [CW_W-1:0]   hs_next_cw;
  logic [SW_W-1:0]   hs_mask;
  phase_t            hs_next_ph;

  // Saturating increment of the shared timeout counter.
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;

  // One control tick: axis check, enable, fault, then the phase step.
  always_comb begin
    phase_nxt     = phase_r;
    prev_en_nxt   = item.enable;
    prev_axis_nxt = item.axis_id;
    edge_nxt      = edge_r;
    cnt_nxt       = cnt_r;
    cur_ph        = phase_r;
    res           = '0;
    hs_active     = 1'b0;
    hs_last       = 1'b0;
    hs_cw         = '0;
    hs_next_cw    = '0;
    hs_mask       = '0;
    hs_next_ph    = PH_ERROR;

    // An axis change while enabled stops the previous axis.
    if (item.enable && prev_en_r && (item.axis_id != prev_axis_r)) begin
      res.axis_state_command = CMD_ERROR_STOP;
      cur_ph                 = PH_READY;
    end
    phase_nxt = cur_ph;

    if (!item.enable) begin
      edge_nxt  = 1'b0;
      phase_nxt = PH_READY;
    end else begin
      if (item.axis_fault) begin
        cur_ph    = PH_ERROR;
        phase_nxt = PH_ERROR;
        res.error = 1'b1;
        cnt_nxt   = '0;
      end
      res.target_write = (cur_ph != PH_READY);

      unique case (cur_ph)
        PH_READY: begin
          edge_nxt = 1'b1;
          // Only a rising edge of enable starts a sequence.
          if (!edge_r) begin
            if (!item.axis_powered_off) begin
              phase_nxt = PH_ERROR;
              res.error = 1'b1;
              cnt_nxt   = '0;
            end else begin
              res.set_csp_mode = 1'b1;
              cnt_nxt          = '0;
              if (item.axis_virtual) begin
                res.done_res           = 1'b1;
                res.axis_state_command = CMD_STANDSTILL;
                phase_nxt              = PH_FINISH;
              end else begin
                res.control_write = 1'b1;
                res.control_word  = cfg.init_control_word;
                res.busy_res      = 1'b1;
                phase_nxt         = PH_START;
              end
            end
          end
        end
        PH_START: begin
          res.control_write = 1'b1;
          res.control_word  = CW_EV | CW_QS;
          res.busy_res      = 1'b1;
          phase_nxt         = PH_W06;
        end
        PH_W06: begin
          hs_active  = 1'b1;
          hs_cw      = CW_EV | CW_QS;
          hs_mask    = SW_QS | SW_RTSO;
          hs_next_cw = CW_EV | CW_QS | CW_SO;
          hs_next_ph = PH_W07;
        end
        PH_W07: begin
          hs_active  = 1'b1;
          hs_cw      = CW_EV | CW_QS | CW_SO;
          hs_mask    = SW_QS | SW_RTSO | SW_SO;
          hs_next_cw = CW_EV | CW_QS | CW_SO | CW_EO;
          hs_next_ph = PH_W0F;
        end
        PH_W0F: begin
          hs_active  = 1'b1;
          hs_last    = 1'b1;
          hs_cw      = CW_EV | CW_QS | CW_SO | CW_EO;
          hs_mask    = SW_QS | SW_RTSO | SW_SO | SW_OE;
          hs_next_ph = PH_FINISH;
        end
        PH_FINISH: begin
          edge_nxt     = 1'b1;
          res.done_res = 1'b1;
        end
        PH_ERROR: begin
          edge_nxt  = 1'b1;
          res.error = 1'b1;
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase

      // Drive handshake: hold the control word until the status bits match.
      if (hs_active) begin
        res.control_write = 1'b1;
        res.control_word  = hs_cw;
        res.busy_res      = 1'b1;
        if ((item.status_word & hs_mask) == hs_mask) begin
          phase_nxt = hs_next_ph;
          if (hs_last) begin
            res.done_res           = 1'b1;
            res.axis_state_command = CMD_STANDSTILL;
          end else begin
            res.control_word = hs_next_cw;
          end
        end else begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= cfg.timeout_ticks) begin
            phase_nxt              = PH_ERROR;
            res.axis_state_command = CMD_ERROR_STOP;
            res.error              = 1'b1;
            res.busy_res           = 1'b0;
            res.error_code         = ERR_CODE_TIMEOUT;
            cnt_nxt                = '0;
          end
        end
      end
    end

    res.target_position = res.target_write ? item.actual_position : '0;
  end

  // Sequencer state moves once per processed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_READY;
      prev_en_r   <= 1'b0;
      edge_r      <= 1'b0;
      prev_axis_r <= '0;
      cnt_r       <= '0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      prev_en_r   <= prev_en_nxt;
      edge_r      <= edge_nxt;
      prev_axis_r <= prev_axis_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // The timeout code is never reported without the error flag.
  a_code_needs_error: assert property (@(posedge clk) disable iff (!rst_n)
    res.error_code |-> res.error)
    else $error("error code set without error flag");

  // Done and error never come together.
  a_done_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.done_res && res.error))
    else $error("done and error in the same result");

  // With enable low in the processed word, the sequence is back at ready.
  a_disable_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !item.enable) |=> (phase_r == PH_READY))
    else $error("phase not ready after enable low");

  // Every sequence that enters the start phase begins with a cleared counter.
  a_cnt_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (phase_nxt == PH_START)) |=> (cnt_r == '0))
    else $error("timeout counter not cleared at sequence start");

endmodule

`default_nettype wire

// File: rtl/servo_drive_power_on_sequencer.sv
// Power-on sequencer for one CiA 402 servo axis. Each input word is one
// control tick; each produces exactly one result word. On a rising edge of
// in_enable the block requests CSP mode, writes the init control word, then
// steps the drive through control words 0x06, 0x07 and 0x0F, waiting each
// time for the matching status bits, and ends in done or error. One shared
// counter bounds the total wait to timeout_ticks ticks. A word passes an
// input register and then a result register; a new word is taken every
// cycle while out_ready is high, and the sequencer state update between
// the two registers sets that rate. Configuration (index 0 timeout_ticks,
// index 1 init_control_word) is written through the cfg_ port, and the user
// writes it only while no word is in flight (not enforced by the block).
`default_nettype none

module servo_drive_power_on_sequencer
  import spos_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CIDX_W-1:0]       cfg_index,
  input  wire logic [CDATA_W-1:0]      cfg_data,

  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_enable,
  input  wire logic [AXIS_W-1:0]       in_axis_id,
  input  wire logic [SW_W-1:0]         in_status_word,
  input  wire logic                    in_axis_fault,
  input  wire logic                    in_axis_powered_off,
  input  wire logic                    in_axis_virtual,
  input  wire logic signed [POS_W-1:0] in_actual_position,

  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_busy_res,
  output logic                         out_done_res,
  output logic                         out_error,
  output logic                         out_error_code,
  output logic                         out_control_write,
  output logic [CW_W-1:0]              out_control_word,
  output logic                         out_set_csp_mode,
  output logic [CMD_W-1:0]             out_axis_state_command,
  output logic                         out_target_write,
  output logic signed [POS_W-1:0]      out_target_position
);

  cfg_t    cfg;
  item_t   in_r, in_nxt;
  logic    in_vld_r, in_vld_nxt;
  result_t out_r, res;
  logic    out_vld_r, out_vld_nxt;
  logic    advance;
  logic    in_take;

  // Configuration registers
  assign cfg_ready = 1'b1;

  spos_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pipeline control: a word moves on when the result register is empty or is being read.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_nxt                  = in_r;
    in_vld_nxt              = in_vld_r;
    out_vld_nxt             = out_vld_r;
    if (in_take) begin
      in_nxt.enable           = in_enable;
      in_nxt.axis_id          = in_axis_id;
      in_nxt.status_word      = in_status_word;
      in_nxt.axis_fault       = in_axis_fault;
      in_nxt.axis_powered_off = in_axis_powered_off;
      in_nxt.axis_virtual     = in_axis_virtual;
      in_nxt.actual_position  = in_actual_position;
      in_vld_nxt              = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    in_r <= in_nxt;
    if (advance) begin
      out_r <= res;
    end
  end

  // Sequencer step
  spos_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Result ports
  assign out_valid              = out_vld_r;
  assign out_busy_res           = out_r.busy_res;
  assign out_done_res           = out_r.done_res;
  assign out_error              = out_r.error;
  assign out_error_code         = out_r.error_code;
  assign out_control_write      = out_r.control_write;
  assign out_control_word       = out_r.control_word;
  assign out_set_csp_mode       = out_r.set_csp_mode;
  assign out_axis_state_command = out_r.axis_state_command;
  assign out_target_write       = out_r.target_write;
  assign out_target_position    = out_r.target_position;

  // Input side only stalls while a word is held behind a full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a full pipeline");

  // Target position is zero unless a target write is reported.
  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_target_write) |-> (out_target_position == '0))
    else $error("target position without target write");

  // No control word is shown unless it is written.
  a_cw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_control_write) |-> (out_control_word == '0))
    else $error("control word without control write");

endmodule

`default_nettype wire

// File: test/servo_drive_power_on_sequencer_tb.sv
module servo_drive_power_on_sequencer_tb;
  import spos_pkg::*;

  // Sequencer phases as the predictor tracks them.
  typedef enum logic [2:0] {
    SEQ_READY, SEQ_START, SEQ_W06, SEQ_W07, SEQ_W0F, SEQ_FINISH, SEQ_ERROR
  } seq_phase_t;

  // Predicts the result word of every accepted input word and checks the
  // results that the block returns, in order.
  class power_on_scoreboard_t;
    logic [CNT_W-1:0]  timeout_ticks;
    logic [CW_W-1:0]   init_cw;
    seq_phase_t        phase;
    bit                prev_enable;
    bit                edge_seen;
    logic [AXIS_W-1:0] prev_axis;
    logic [CNT_W-1:0]  wait_ticks;
    result_t           expected_q[$];
    int                failures;
    int                checked;

    function new();
      timeout_ticks = TIMEOUT_RST;
      init_cw       = INIT_CW_RST;
      phase         = SEQ_READY;
      prev_enable   = 1'b0;
      edge_seen     = 1'b0;
      prev_axis     = '0;
      wait_ticks    = '0;
      failures      = 0;
      checked       = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
      case (idx)
        CFG_TIMEOUT: timeout_ticks = data[CNT_W-1:0];
        CFG_INIT_CW: init_cw = data[CW_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // One waiting phase: hold the control word, move on once the status
    // bits are all set, otherwise count toward the shared timeout.
    function void await_status(inout result_t r, input logic [SW_W-1:0] sw,
                               input logic [CW_W-1:0] cw, input logic [SW_W-1:0] mask,
                               input logic [CW_W-1:0] next_cw, input seq_phase_t next_ph);
      r.control_write = 1'b1;
      r.control_word  = cw;
      r.busy_res      = 1'b1;
      if ((sw & mask) == mask) begin
        if (next_ph == SEQ_FINISH) begin
          r.done_res           = 1'b1;
          r.axis_state_command = CMD_STANDSTILL;
        end else begin
          r.control_word = next_cw;
        end
        phase = next_ph;
      end else begin
        if (wait_ticks != CNT_MAX)
          wait_ticks++;
        if (wait_ticks >= timeout_ticks) begin
          phase                = SEQ_ERROR;
          r.axis_state_command = CMD_ERROR_STOP;
          r.error              = 1'b1;
          r.busy_res           = 1'b0;
          r.error_code         = ERR_CODE_TIMEOUT;
          wait_ticks           = '0;
        end
      end
    endfunction

    // Advances the sequencer by one control tick and queues its result word.
    function void note_word(item_t w);
      result_t r;
      r = '0;
      // An axis change while enabled stops the old axis and drops to ready.
      if (w.enable && prev_enable && w.axis_id != prev_axis) begin
        r.axis_state_command = CMD_ERROR_STOP;
        phase = SEQ_READY;
      end
      prev_axis   = w.axis_id;
      prev_enable = w.enable;
      if (!w.enable) begin
        edge_seen = 1'b0;
        phase     = SEQ_READY;
      end else begin
        if (w.axis_fault) begin
          phase      = SEQ_ERROR;
          r.error    = 1'b1;
          wait_ticks = '0;
        end
        if (phase != SEQ_READY) begin
          r.target_write    = 1'b1;
          r.target_position = w.actual_position;
        end
        case (phase)
          SEQ_READY: begin
            if (!edge_seen) begin
              if (!w.axis_powered_off) begin
                phase      = SEQ_ERROR;
                r.error    = 1'b1;
                wait_ticks = '0;
              end else if (w.axis_virtual) begin
                r.set_csp_mode       = 1'b1;
                r.done_res           = 1'b1;
                r.axis_state_command = CMD_STANDSTILL;
                phase                = SEQ_FINISH;
                wait_ticks           = '0;
              end else begin
                r.set_csp_mode  = 1'b1;
                r.control_write = 1'b1;
                r.control_word  = init_cw;
                r.busy_res      = 1'b1;
                phase           = SEQ_START;
                wait_ticks      = '0;
              end
            end
            edge_seen = 1'b1;
          end
          SEQ_START: begin
            r.control_write = 1'b1;
            r.control_word  = CW_EV | CW_QS;
            r.busy_res      = 1'b1;
            phase           = SEQ_W06;
          end
          SEQ_W06: await_status(r, w.status_word, CW_EV | CW_QS, SW_QS | SW_RTSO,
                                CW_EV | CW_QS | CW_SO, SEQ_W07);
          SEQ_W07: await_status(r, w.status_word, CW_EV | CW_QS | CW_SO,
                                SW_QS | SW_RTSO | SW_SO,
                                CW_EV | CW_QS | CW_SO | CW_EO, SEQ_W0F);
          SEQ_W0F: await_status(r, w.status_word, CW_EV | CW_QS | CW_SO | CW_EO,
                                SW_QS | SW_RTSO | SW_SO | SW_OE, '0, SEQ_FINISH);
          SEQ_FINISH: begin
            edge_seen  = 1'b1;
            r.done_res = 1'b1;
          end
          SEQ_ERROR: begin
            edge_seen = 1'b1;
            r.error   = 1'b1;
          end
          default: phase = SEQ_ERROR;
        endcase
      end
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("result %0d: %s expected %0h, got %0h", checked, name, want, got);
      end
    endfunction

    // Compares one returned result word with the oldest prediction.
    function void check_result(result_t got);
      result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result %0d arrived with no word outstanding", checked);
        return;
      end
      want = expected_q.pop_front();
      compare_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
      compare_field("error", 32'(want.error), 32'(got.error));
      compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
      compare_field("control_write", 32'(want.control_write), 32'(got.control_write));
      compare_field("control_word", 32'(want.control_word), 32'(got.control_word));
      compare_field("set_csp_mode", 32'(want.set_csp_mode), 32'(got.set_csp_mode));
      compare_field("axis_state_command", 32'(want.axis_state_command),
                    32'(got.axis_state_command));
      compare_field("target_write", 32'(want.target_write), 32'(got.target_write));
      compare_field("target_position", want.target_position, got.target_position);
    endfunction
  endclass

  localparam int QUIET_LIMIT = 2000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CIDX_W-1:0]       cfg_index = '0;
  logic [CDATA_W-1:0]      cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_enable = 1'b0;
  logic [AXIS_W-1:0]       in_axis_id = '0;
  logic [SW_W-1:0]         in_status_word = '0;
  logic                    in_axis_fault = 1'b0;
  logic                    in_axis_powered_off = 1'b0;
  logic                    in_axis_virtual = 1'b0;
  logic signed [POS_W-1:0] in_actual_position = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_busy_res;
  logic                    out_done_res;
  logic                    out_error;
  logic                    out_error_code;
  logic                    out_control_write;
  logic [CW_W-1:0]         out_control_word;
  logic                    out_set_csp_mode;
  logic [CMD_W-1:0]        out_axis_state_command;
  logic                    out_target_write;
  logic signed [POS_W-1:0] out_target_position;

  power_on_scoreboard_t books = new();
  int send_idle = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int quiet_cycles = 0;

  servo_drive_power_on_sequencer i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_enable              (in_enable),
    .in_axis_id             (in_axis_id),
    .in_status_word         (in_status_word),
    .in_axis_fault          (in_axis_fault),
    .in_axis_powered_off    (in_axis_powered_off),
    .in_axis_virtual        (in_axis_virtual),
    .in_actual_position     (in_actual_position),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_busy_res           (out_busy_res),
    .out_done_res           (out_done_res),
    .out_error              (out_error),
    .out_error_code         (out_error_code),
    .out_control_write      (out_control_write),
    .out_control_word       (out_control_word),
    .out_set_csp_mode       (out_set_csp_mode),
    .out_axis_state_command (out_axis_state_command),
    .out_target_write       (out_target_write),
    .out_target_position    (out_target_position)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check every accepted word and stall at random.
  always @(posedge clk) begin
    if (out_valid && out_ready)
      books.check_result({out_busy_res, out_done_res, out_error, out_error_code,
                          out_control_write, out_control_word, out_set_csp_mode,
                          out_axis_state_command, out_target_write,
                          out_target_position});
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Ends the run when no channel has moved a word for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic item_t make_word(logic en, logic [AXIS_W-1:0] axis,
                                      logic [SW_W-1:0] sw, logic fault, logic poff,
                                      logic virt, logic [POS_W-1:0] pos);
    item_t w;
    w.enable           = en;
    w.axis_id          = axis;
    w.status_word      = sw;
    w.axis_fault       = fault;
    w.axis_powered_off = poff;
    w.axis_virtual     = virt;
    w.actual_position  = pos;
    return w;
  endfunction

  function automatic item_t noise_word();
    return make_word(1'($urandom_range(1)), AXIS_W'($urandom_range(255)),
                     SW_W'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), POS_W'($urandom));
  endfunction

  // Status word for the current wait: usually the bits it waits for, with
  // random other bits, otherwise with at least one of them missing.
  function automatic logic [SW_W-1:0] status_for(seq_phase_t ph);
    logic [SW_W-1:0] mask;
    logic [SW_W-1:0] sw;
    logic [SW_W-1:0] miss;
    sw = SW_W'($urandom);
    case (ph)
      SEQ_W06: mask = SW_QS | SW_RTSO;
      SEQ_W07: mask = SW_QS | SW_RTSO | SW_SO;
      SEQ_W0F: mask = SW_QS | SW_RTSO | SW_SO | SW_OE;
      default: return sw;
    endcase
    if ($urandom_range(99) < 55)
      return sw | mask;
    miss = mask & SW_W'($urandom);
    if (miss == '0)
      miss = SW_QS;
    return sw & ~miss;
  endfunction

  // Presents one word and holds it until the block takes it.
  task automatic send_word(input item_t w);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid            <= 1'b1;
    in_enable           <= w.enable;
    in_axis_id          <= w.axis_id;
    in_status_word      <= w.status_word;
    in_axis_fault       <= w.axis_fault;
    in_axis_powered_off <= w.axis_powered_off;
    in_axis_virtual     <= w.axis_virtual;
    in_actual_position  <= w.actual_position;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    books.note_word(w);
    words_sent++;
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic settle();
    if (in_valid)
      in_valid <= 1'b0;
    while (books.pending() != 0) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CNT_W-1:0] limit, input logic [CW_W-1:0] cw);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= CDATA_W'(limit);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    books.write_reg(CFG_TIMEOUT, CDATA_W'(limit));
    cfg_index <= CFG_INIT_CW;
    cfg_data  <= CDATA_W'(cw);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    books.write_reg(CFG_INIT_CW, CDATA_W'(cw));
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_setting();
    logic [CNT_W-1:0] limit;
    logic [CW_W-1:0]  cw;
    case ($urandom_range(5))
      0: limit = 20'd1;
      1: limit = 20'd1000000;
      2: limit = CNT_W'($urandom_range(13, 60));
      default: limit = CNT_W'($urandom_range(2, 12));
    endcase
    case ($urandom_range(2))
      0: cw = '0;
      1: cw = 16'hFFFF;
      default: cw = CW_W'($urandom);
    endcase
    write_setting(limit, cw);
  endtask

  // One power-on attempt on one axis: enable low, then enable high ticks with
  // status words that step the drive along, with the odd fault, axis change
  // or enable drop mixed in. Ends a few ticks after done or error.
  task automatic run_sequence();
    item_t             w;
    logic [AXIS_W-1:0] axis;
    int                hold;
    axis = AXIS_W'($urandom_range(255));
    hold = $urandom_range(3);
    w = noise_word();
    w.enable = 1'b0;
    send_word(w);
    for (int n = 0; n < 60; n++) begin
      w = noise_word();
      w.enable      = 1'b1;
      w.axis_id     = axis;
      w.axis_fault  = ($urandom_range(99) < 3);
      w.status_word = status_for(books.phase);
      if (n == 0) begin
        w.axis_powered_off = ($urandom_range(99) < 90);
        w.axis_virtual     = ($urandom_range(99) < 15);
      end
      if ($urandom_range(99) < 3)
        w.axis_id = axis ^ AXIS_W'($urandom_range(1, 255));
      if ($urandom_range(99) < 2)
        w.enable = 1'b0;
      send_word(w);
      if (!w.enable || w.axis_id != axis)
        break;
      if (books.phase == SEQ_FINISH || books.phase == SEQ_ERROR) begin
        if (hold == 0)
          break;
        hold--;
      end
    end
  endtask

  initial begin
    int stop_at;
    int next_cfg;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: a full power-on with extreme
    // positions, an axis change while enabled, start without power off,
    // a fault in the error phase, a virtual axis and a fault while waiting.
    send_word(make_word(0, 8'h00, 16'h0000, 0, 0, 0, 32'h0000_0000));
    send_word(make_word(1, 8'h00, 16'h0000, 0, 1, 0, 32'h7FFF_FFFF));
    send_word(make_word(1, 8'h00, 16'hFFDE, 0, 1, 0, 32'h8000_0000));
    send_word(make_word(1, 8'h00, 16'h0021, 0, 1, 0, 32'hFFFF_FFFF));
    send_word(make_word(1, 8'h00, 16'h0023, 0, 0, 1, 32'h0000_0000));
    send_word(make_word(1, 8'h00, 16'h0027, 0, 1, 0, 32'h0000_0001));
    send_word(make_word(1, 8'h00, 16'hFFFF, 0, 1, 1, 32'h1234_5678));
    send_word(make_word(1, 8'hFF, 16'hFFFF, 0, 1, 0, 32'h8765_4321));
    send_word(make_word(1, 8'hFF, 16'h0000, 0, 1, 0, 32'h0000_0000));
    send_word(make_word(0, 8'hFF, 16'hFFFF, 1, 1, 1, 32'hFFFF_FFFF));
    send_word(make_word(1, 8'hFF, 16'h0000, 0, 0, 0, 32'h0000_0010));
    send_word(make_word(1, 8'hFF, 16'h0000, 1, 0, 0, 32'h0000_0020));
    send_word(make_word(0, 8'h00, 16'h0000, 0, 0, 0, 32'h0000_0000));
    send_word(make_word(1, 8'h5A, 16'h0000, 0, 1, 1, 32'hDEAD_BEEF));
    send_word(make_word(0, 8'h5A, 16'h0000, 0, 1, 1, 32'h0000_0000));
    send_word(make_word(1, 8'hA5, 16'h0000, 0, 1, 0, 32'h0000_0100));
    send_word(make_word(1, 8'hA5, 16'h0000, 0, 1, 0, 32'h0000_0200));
    send_word(make_word(1, 8'hA5, 16'h0000, 1, 1, 0, 32'h0000_0300));
    send_word(make_word(1, 8'hA5, 16'h0020, 0, 1, 0, 32'h0000_0400));

    // Shortest timeout and an all-ones init control word: the first
    // waiting tick without the status bits times out.
    settle();
    write_setting(20'd1, 16'hFFFF);
    send_word(make_word(0, 8'h3C, 16'h0000, 0, 0, 0, 32'h0000_0000));
    send_word(make_word(1, 8'h3C, 16'h0000, 0, 1, 0, 32'h0000_0001));
    send_word(make_word(1, 8'h3C, 16'h0000, 0, 1, 0, 32'h0000_0002));
    send_word(make_word(1, 8'h3C, 16'hFFDE, 0, 1, 0, 32'h0000_0003));
    send_word(make_word(1, 8'h3C, 16'hFFFF, 0, 1, 0, 32'h0000_0004));
    send_word(make_word(0, 8'h3C, 16'h0000, 0, 0, 0, 32'h0000_0000));

    // Random part in four idling phases, with a new setting now and then.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 54; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 54; end
        default: begin send_idle = 10; stall_pct = 10; end
      endcase
      settle();
      if (p == 0)
        write_setting(20'd1000000, 16'h0000);
      else
        pick_setting();
      stop_at  = words_sent + 320;
      next_cfg = words_sent + 90 + $urandom_range(40);
      while (words_sent < stop_at) begin
        if (words_sent >= next_cfg) begin
          settle();
          pick_setting();
          next_cfg = words_sent + 90 + $urandom_range(40);
        end
        if ($urandom_range(99) < 85)
          run_sequence();
        else
          repeat ($urandom_range(1, 6)) send_word(noise_word());
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (books.failures == 0 && books.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
rtl/spos_pkg.sv
rtl/spos_cfg.sv
rtl/spos_core.sv
rtl/servo_drive_power_on_sequencer.sv
test/servo_drive_power_on_sequencer_tb.sv
